@@ design/utp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types and constants of the utf-8 text grid parser.
// ----------------------------------------------------------------------------
package utp_pkg;

    // configuration port
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0]  REG_GRID_COLUMNS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  REG_GRID_ROWS      = 1'b1;
    localparam logic [CFG_DATA_W-1:0] GRID_COLUMNS_RESET = 11'd320;
    localparam logic [CFG_DATA_W-1:0] GRID_ROWS_RESET    = 11'd96;
    localparam logic [CFG_DATA_W-1:0] POS_LIMIT          = 11'd1024;

    // result kinds
    localparam logic [1:0] KIND_CELL     = 2'd0;
    localparam logic [1:0] KIND_EOT      = 2'd1;
    localparam logic [1:0] KIND_BAD_LEAD = 2'd2;
    localparam logic [1:0] KIND_BAD_CONT = 2'd3;

    // characters
    localparam logic [7:0] CHAR_NUL      = 8'h00;
    localparam logic [7:0] CHAR_LF       = 8'h0a;
    localparam logic [7:0] CHAR_CR       = 8'h0d;
    localparam logic [7:0] CHAR_ESC      = 8'h1b;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z  = 8'h7a;

    // utf-8 lead byte classes
    localparam logic [7:0] MASK_1B = 8'h80;
    localparam logic [7:0] MASK_2B = 8'he0;
    localparam logic [7:0] LEAD_2B = 8'hc0;
    localparam logic [7:0] MASK_3B = 8'hf0;
    localparam logic [7:0] LEAD_3B = 8'he0;
    localparam logic [7:0] MASK_4B = 8'hf8;
    localparam logic [7:0] LEAD_4B = 8'hf0;
    localparam logic [7:0] MASK_CONT = 8'hc0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // operations handed from the front to the back
    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_CELL     = 3'd1,
        OP_EOT      = 3'd2,
        OP_BAD_LEAD = 3'd3,
        OP_BAD_CONT = 3'd4,
        OP_GROW     = 3'd5
    } op_t;

    // one request: up to two operations, op_a first
    typedef struct packed {
        op_t         op_a;
        logic [31:0] a_bytes;
        logic [2:0]  a_len;
        op_t         op_b;
        logic [7:0]  b_byte;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  column;
        logic [9:0]  row;
        logic [31:0] bytes;
        logic [2:0]  length;
        logic        oob;
        logic [10:0] used_columns;
        logic [10:0] used_rows;
        logic        last;
    } res_t;

endpackage
`default_nettype wire

@@ design/utf8_ansi_text_grid_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_ansi_text_grid_parser
// UTF-8 text to cell grid parser with ANSI CSI skipping.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while full is low. A byte that needs two operations
// (an escape or a broken codepoint followed by a byte that gives a result of
// its own, or NUL inside a CSI sequence) holds the grid tracker for both, as
// the tracker carries out one operation per cycle while its result queue has
// room and sets the sustained rate. Two-entry queues sit between classifier
// and tracker and on the result side, so a result passes through the request
// queue and then the result queue, and the input keeps flowing while a result
// waits.
// grid_columns and grid_rows are written through cfg_write/cfg_index/cfg_data
// and should only change while no text is in flight.
module utf8_ansi_text_grid_parser
    import utp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire logic [7:0]            data_byte,
    output logic                       empty,
    input  wire logic                  pop,
    output logic [1:0]                 result_kind,
    output logic [9:0]                 cell_column,
    output logic [9:0]                 cell_row,
    output logic [31:0]                codepoint_bytes,
    output logic [2:0]                 codepoint_length,
    output logic                       out_of_bounds,
    output logic [10:0]                used_columns,
    output logic [10:0]                used_rows,
    output logic                       last_of_run,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] grid_columns_reg;
    logic [CFG_DATA_W-1:0] grid_rows_reg;

    logic byte_valid;
    logic cmd_push, cmd_full, cmd_valid, cmd_pop;
    cmd_t front_cmd, head_cmd;
    res_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= GRID_COLUMNS_RESET;
            grid_rows_reg    <= GRID_ROWS_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                default:          grid_rows_reg    <= grid_rows_reg;
            endcase
        end
    end

    assign full       = cmd_full;
    assign byte_valid = push && !cmd_full;

    utp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .data_byte  (data_byte),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd)
    );

    utp_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (front_cmd),
        .full     (cmd_full),
        .rd_valid (cmd_valid),
        .rd_en    (cmd_pop),
        .rd_data  (head_cmd)
    );

    utp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (head_cmd),
        .cmd_pop      (cmd_pop),
        .res_empty    (empty),
        .res_pop      (pop),
        .res          (res)
    );

    assign result_kind      = res.kind;
    assign cell_column      = res.column;
    assign cell_row         = res.row;
    assign codepoint_bytes  = res.bytes;
    assign codepoint_length = res.length;
    assign out_of_bounds    = res.oob;
    assign used_columns     = res.used_columns;
    assign used_rows        = res.used_rows;
    assign last_of_run      = res.last;

    // a placed cell carries one to four bytes
    a_cell_length: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_CELL) |->
            (codepoint_length >= 3'd1 && codepoint_length <= 3'd4))
        else $error("cell result with bad byte count");

    // other kinds carry no length and never flag a held move
    a_other_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind != KIND_CELL) |->
            (codepoint_length == 3'd0 && !out_of_bounds))
        else $error("non-cell result with length or bounds flag");

    // a placed cell always lies inside the used dimensions it reports
    a_cell_in_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result_kind == KIND_CELL) |->
            ({1'b0, cell_column} < used_columns && {1'b0, cell_row} < used_rows))
        else $error("cell outside reported dimensions");

    // a stalled request in the middle queue never blocks the input side forever
    a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !empty && pop) |=> (cmd_pop || !cmd_valid || $past(cmd_pop)
            || !empty))
        else $error("request queue stuck with room on the result side");

endmodule
`default_nettype wire

@@ design/utp_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utp_front
// Byte classifier: utf-8 grouping, escape and csi skipping, error detection.
// ----------------------------------------------------------------------------
module utp_front
    import utp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic [7:0] data_byte,
    output logic            cmd_push,
    output cmd_t            cmd
);

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'b0001,
        MODE_ESC    = 4'b0010,
        MODE_CSI    = 4'b0100,
        MODE_MULTI  = 4'b1000
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [31:0] partial_reg, partial_next;
    logic [2:0]  exp_reg, exp_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic        run_normal;
    logic        is_letter;
    logic        is_cont;
    logic [2:0]  lead;
    logic [2:0]  cnt_inc;
    logic [31:0] merged;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & MASK_1B) == 8'h00)
            len = 3'd1;
        else if ((b & MASK_2B) == LEAD_2B)
            len = 3'd2;
        else if ((b & MASK_3B) == LEAD_3B)
            len = 3'd3;
        else if ((b & MASK_4B) == LEAD_4B)
            len = 3'd4;
        else
            len = 3'd0;
        return len;
    endfunction

    assign is_letter = (data_byte >= CHAR_UPPER_A && data_byte <= CHAR_UPPER_Z) ||
                       (data_byte >= CHAR_LOWER_A && data_byte <= CHAR_LOWER_Z);
    assign is_cont   = (data_byte & MASK_CONT) == CONT_TAG;
    assign lead      = lead_length(data_byte);
    assign cnt_inc   = cnt_reg + 3'd1;
    assign merged    = partial_reg | (32'(data_byte) << {cnt_reg[1:0], 3'b000});

    always_comb
    begin
        mode_next    = mode_reg;
        partial_next = partial_reg;
        exp_next     = exp_reg;
        cnt_next     = cnt_reg;
        run_normal   = 1'b0;
        cmd.op_a     = OP_NONE;
        cmd.a_bytes  = 32'd0;
        cmd.a_len    = 3'd0;
        cmd.op_b     = OP_NONE;
        cmd.b_byte   = data_byte;

        case (mode_reg)
            MODE_NORMAL:
            begin
                run_normal = 1'b1;
            end
            MODE_ESC:
            begin
                if (data_byte == CHAR_LBRACKET)
                begin
                    mode_next = MODE_CSI;
                end
                else
                begin
                    // lone escape becomes a cell, byte then handled as text
                    cmd.op_a    = OP_CELL;
                    cmd.a_bytes = 32'(CHAR_ESC);
                    cmd.a_len   = 3'd1;
                    run_normal  = 1'b1;
                end
            end
            MODE_CSI:
            begin
                if (data_byte == CHAR_NUL)
                begin
                    cmd.op_a  = OP_GROW;
                    cmd.op_b  = OP_EOT;
                    mode_next = MODE_NORMAL;
                end
                else if (is_letter)
                begin
                    cmd.op_a  = OP_GROW;
                    mode_next = MODE_NORMAL;
                end
            end
            MODE_MULTI:
            begin
                if (is_cont && cnt_reg < 3'd4)
                begin
                    if (cnt_inc >= exp_reg)
                    begin
                        cmd.op_a     = OP_CELL;
                        cmd.a_bytes  = merged;
                        cmd.a_len    = exp_reg;
                        mode_next    = MODE_NORMAL;
                        partial_next = 32'd0;
                        exp_next     = 3'd0;
                        cnt_next     = 3'd0;
                    end
                    else
                    begin
                        partial_next = merged;
                        cnt_next     = cnt_inc;
                    end
                end
                else
                begin
                    cmd.op_a     = OP_BAD_CONT;
                    cmd.a_bytes  = partial_reg;
                    partial_next = 32'd0;
                    exp_next     = 3'd0;
                    cnt_next     = 3'd0;
                    run_normal   = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
            end
        endcase

        if (run_normal)
        begin
            mode_next = MODE_NORMAL;
            if (data_byte == CHAR_NUL)
            begin
                cmd.op_b = OP_EOT;
            end
            else if (data_byte == CHAR_ESC)
            begin
                mode_next = MODE_ESC;
            end
            else if (lead == 3'd0)
            begin
                cmd.op_b = OP_BAD_LEAD;
            end
            else if (lead == 3'd1)
            begin
                cmd.op_b = OP_CELL;
            end
            else
            begin
                partial_next = 32'(data_byte);
                exp_next     = lead;
                cnt_next     = 3'd1;
                mode_next    = MODE_MULTI;
            end
        end
    end

    assign cmd_push = byte_valid && (cmd.op_a != OP_NONE || cmd.op_b != OP_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            partial_reg <= 32'd0;
            exp_reg     <= 3'd0;
            cnt_reg     <= 3'd0;
        end
        else if (byte_valid)
        begin
            mode_reg    <= mode_next;
            partial_reg <= partial_next;
            exp_reg     <= exp_next;
            cnt_reg     <= cnt_next;
        end
    end

endmodule
`default_nettype wire

@@ design/utp_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utp_cmd_queue
// Two-entry queue of requests between the classifier and the grid tracker.
// ----------------------------------------------------------------------------
module utp_cmd_queue
    import utp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire cmd_t wr_data,
    output logic      full,
    output logic      rd_valid,
    input  wire logic rd_en,
    output cmd_t      rd_data
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full     = count_reg == 2'd2;
    assign rd_valid = count_reg != 2'd0;
    assign rd_data  = q_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (!do_wr && do_rd)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            q_reg[wr_ptr_reg] <= wr_data;
    end

endmodule
`default_nettype wire

@@ design/utp_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utp_back
// Grid tracker: carries out requests one operation per cycle while the result
// queue has room, keeps the cursor and used dimensions, and queues the results.
// ----------------------------------------------------------------------------
module utp_back
    import utp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [CFG_DATA_W-1:0] grid_columns,
    input  wire logic [CFG_DATA_W-1:0] grid_rows,
    input  wire logic                  cmd_valid,
    input  wire cmd_t                  cmd,
    output logic                       cmd_pop,
    output logic                       res_empty,
    input  wire logic                  res_pop,
    output res_t                       res
);

    logic [9:0]  col_reg, col_next;
    logic [9:0]  row_reg, row_next;
    logic [10:0] max_c_reg, max_c_next;
    logic [10:0] max_r_reg, max_r_next;
    logic        phase_reg;

    res_t        q_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    logic        cur_is_b, done, room, exec, res_push;
    op_t         cur_op;
    logic [31:0] cur_bytes;
    logic [2:0]  cur_len;
    logic [10:0] lim_c, lim_r, nx, ny;
    logic        inb, is_lf, is_cr;
    logic [9:0]  pc, pr;
    logic [10:0] gc, gr, grown_c, grown_r;
    res_t        new_res;
    logic        do_rd;

    assign cur_is_b  = phase_reg || cmd.op_a == OP_NONE;
    assign cur_op    = cur_is_b ? cmd.op_b : cmd.op_a;
    assign cur_bytes = cur_is_b ? ((cmd.op_b == OP_EOT) ? 32'd0 : 32'(cmd.b_byte))
                                : cmd.a_bytes;
    assign cur_len   = cur_is_b ? 3'd1 : cmd.a_len;
    assign done      = cur_is_b || cmd.op_b == OP_NONE;
    assign room      = count_reg != 2'd2;
    assign exec      = cmd_valid && room;
    assign cmd_pop   = exec && done;

    // cursor move of a placed cell, held when it would leave the grid
    assign lim_c = (grid_columns > POS_LIMIT) ? POS_LIMIT : grid_columns;
    assign lim_r = (grid_rows > POS_LIMIT) ? POS_LIMIT : grid_rows;
    assign is_lf = cur_len == 3'd1 && cur_bytes[7:0] == CHAR_LF;
    assign is_cr = cur_len == 3'd1 && cur_bytes[7:0] == CHAR_CR;
    assign nx    = (is_lf || is_cr) ? 11'd0 : {1'b0, col_reg} + 11'd1;
    assign ny    = is_lf ? {1'b0, row_reg} + 11'd1 : {1'b0, row_reg};
    assign inb   = nx < lim_c && ny < lim_r;
    assign pc    = (cur_op == OP_CELL && inb) ? nx[9:0] : col_reg;
    assign pr    = (cur_op == OP_CELL && inb) ? ny[9:0] : row_reg;
    assign gc    = {1'b0, pc} + 11'd1;
    assign gr    = {1'b0, pr} + 11'd1;
    assign grown_c = (gc > max_c_reg) ? gc : max_c_reg;
    assign grown_r = (gr > max_r_reg) ? gr : max_r_reg;

    always_comb
    begin
        col_next             = col_reg;
        row_next             = row_reg;
        max_c_next           = max_c_reg;
        max_r_next           = max_r_reg;
        res_push             = 1'b0;
        new_res.kind         = KIND_CELL;
        new_res.column       = col_reg;
        new_res.row          = row_reg;
        new_res.bytes        = cur_bytes;
        new_res.length       = 3'd0;
        new_res.oob          = 1'b0;
        new_res.used_columns = max_c_reg;
        new_res.used_rows    = max_r_reg;
        new_res.last         = done;

        case (cur_op)
            OP_CELL:
            begin
                col_next             = pc;
                row_next             = pr;
                max_c_next           = grown_c;
                max_r_next           = grown_r;
                res_push             = 1'b1;
                new_res.length       = cur_len;
                new_res.oob          = !inb;
                new_res.used_columns = grown_c;
                new_res.used_rows    = grown_r;
            end
            OP_GROW:
            begin
                max_c_next = grown_c;
                max_r_next = grown_r;
            end
            OP_EOT:
            begin
                res_push     = 1'b1;
                new_res.kind = KIND_EOT;
                col_next     = 10'd0;
                row_next     = 10'd0;
                max_c_next   = 11'd0;
                max_r_next   = 11'd0;
            end
            OP_BAD_LEAD:
            begin
                res_push     = 1'b1;
                new_res.kind = KIND_BAD_LEAD;
            end
            OP_BAD_CONT:
            begin
                res_push     = 1'b1;
                new_res.kind = KIND_BAD_CONT;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= 10'd0;
            row_reg   <= 10'd0;
            max_c_reg <= 11'd0;
            max_r_reg <= 11'd0;
            phase_reg <= 1'b0;
        end
        else if (exec)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            max_c_reg <= max_c_next;
            max_r_reg <= max_r_next;
            phase_reg <= !done;
        end
    end

    // result queue
    assign res_empty = count_reg == 2'd0;
    assign res       = q_reg[rd_ptr_reg];
    assign do_rd     = res_pop && !res_empty;

    always_comb
    begin
        count_next = count_reg;
        if ((exec && res_push) && !do_rd)
            count_next = count_reg + 2'd1;
        else if (!(exec && res_push) && do_rd)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (exec && res_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_rd)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec && res_push)
            q_reg[wr_ptr_reg] <= new_res;
    end

endmodule
`default_nettype wire
